FILE: design/rqid_pkg.sv
// Shared types and constants for the request id pool allocator.
`timescale 1ns / 1ps
package rqid_pkg;

	// Widths fixed by the item fields and the pool size register
	localparam int unsigned ID_W   = 6;
	localparam int unsigned SIZE_W = 7;

	// Pool size after reset
	localparam logic [SIZE_W-1:0] POOL_SIZE_RST = 7'd64;

	// Request kinds
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_EMPTY      = 2'd1;
	localparam logic [1:0] ST_NOT_IN_USE = 2'd2;

	// Input item
	typedef struct packed {
		logic            action;
		logic [ID_W-1:0] req_id;
	} req_t;

	// Result item
	typedef struct packed {
		logic [ID_W-1:0] granted_id;
		logic [1:0]      status;
	} rsp_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;

endpackage

FILE: design/request_id_pool_allocator_top.sv
// Top level of the request id pool allocator.
//
// Hands out request ids from a pool in first-freed, first-reused order.
// Input channel (in_valid/in_ready/in_data): one item is an allocate or a free
// of req_id. Output channel (out_valid/out_ready/out_data): exactly one result
// item per input item, with the granted id and a status code.
// Configuration: a write of cfg_wdata with cfg_we sets the pool size and resets
// the pool to all ids free, ids 0 up to size-1 queued in ascending order.
// Each item passes through capture, an execute step behind the registered read
// of the free queue memory, and the result hold, in which the result is valid.
// One item is in flight at a time.
// Reset brings the pool to 64 ids (saturated at POOL_DEPTH), all free; no
// clearing pass is needed. While the receiver holds out_ready low the result
// stays unchanged and no new item is accepted.
`timescale 1ns / 1ps
module request_id_pool_allocator_top
	import rqid_pkg::*;
#(
	parameter int unsigned POOL_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  req_t              in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rsp_t              out_data,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata
);

	cmd_t cmd;

	// Sequencing of each item.
	rqid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Pool storage and decisions.
	rqid_dp #(
		.POOL_DEPTH (POOL_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_data  (out_data)
	);

`ifndef SYNTH
	// The block never offers a result while it can take a new item.
	assert property (@(posedge clk) disable iff (!arst_n) !(out_valid && in_ready))
		else $error("result offered while accepting items");

	// An accepted item yields its result once it has passed the execute state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> ##2 out_valid)
		else $error("result missing two cycles after accept");

	// Status is always one of the defined codes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == ST_OK || out_data.status == ST_EMPTY
			|| out_data.status == ST_NOT_IN_USE))
		else $error("undefined status code");

	// Only a successful allocate returns a non-zero id.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != ST_OK) |-> (out_data.granted_id == '0))
		else $error("granted id set on failed request");
`endif

endmodule

FILE: design/rqid_ctrl.sv
// Controller state machine for the request id pool allocator.
`timescale 1ns / 1ps
module rqid_ctrl
	import rqid_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state: capture an item, execute it against the pool, hold the result.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = S_RESP;
			end
			S_RESP: begin
				if (out_ready) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Handshake and datapath commands.
	always_comb begin
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			S_RESP: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

FILE: design/rqid_dp.sv
// Datapath for the request id pool allocator: free id queue, pointers and in-use map.
`timescale 1ns / 1ps
module rqid_dp
	import rqid_pkg::*;
#(
	parameter int unsigned POOL_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  req_t                in_data,
	input  logic                cfg_we,
	input  logic [SIZE_W-1:0]   cfg_wdata,
	output rsp_t                out_data
);

	localparam int unsigned IW = $clog2(POOL_DEPTH);
	localparam int unsigned CW = $clog2(POOL_DEPTH + 1);
	localparam int unsigned SW = (CW > SIZE_W) ? CW : SIZE_W;
	localparam int unsigned XW = ((IW > ID_W) ? IW : ID_W) + 1;
	localparam int unsigned RST_EFF = (64 > POOL_DEPTH) ? POOL_DEPTH : 64;
	localparam int unsigned RST_TAIL = RST_EFF % POOL_DEPTH;

	// Free id queue storage; for entries not yet written since the last init the grant uses their index.
	logic [IW-1:0] queue_mem [POOL_DEPTH];
	logic [IW-1:0] rd_q;

	logic [IW-1:0]         head_q;
	logic [IW-1:0]         tail_q;
	logic [IW-1:0]         tail0_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         fill_q;
	logic [POOL_DEPTH-1:0] in_use_q;
	req_t                  req_q;
	rsp_t                  rsp_q;

	logic [CW-1:0] cfg_eff;
	logic [IW-1:0] cfg_tail;
	logic [IW-1:0] head_diff;
	logic          head_written;
	logic [IW-1:0] grant;
	logic [XW-1:0] id_x;
	logic [IW-1:0] id_idx;
	logic          id_oor;
	logic          alloc_ok;
	logic          free_ok;
	logic [IW-1:0] head_inc;
	logic [IW-1:0] tail_inc;

	// Effective pool size on a register write: saturate at the depth.
	// The compare runs at the wider of the two widths so no size bits are lost.
	always_comb begin
		if (SW'(cfg_wdata) > SW'(POOL_DEPTH)) begin
			cfg_eff = CW'(POOL_DEPTH);
		end else begin
			cfg_eff = CW'(cfg_wdata);
		end
		if (cfg_eff == CW'(POOL_DEPTH)) begin
			cfg_tail = '0;
		end else begin
			cfg_tail = cfg_eff[IW-1:0];
		end
	end

	// Whether the head slot has been written since init: its distance from the initial tail.
	always_comb begin
		if (head_q >= tail0_q) begin
			head_diff = head_q - tail0_q;
		end else begin
			head_diff = IW'(CW'(head_q) + CW'(POOL_DEPTH) - CW'(tail0_q));
		end
		head_written = CW'(head_diff) < fill_q;
		grant        = head_written ? rd_q : head_q;
	end

	// Decision for the captured item.
	always_comb begin
		id_x     = XW'(req_q.req_id);
		id_oor   = id_x >= XW'(POOL_DEPTH);
		id_idx   = id_x[IW-1:0];
		alloc_ok = (req_q.action == ACT_ALLOC) && (count_q != '0);
		free_ok  = (req_q.action == ACT_FREE) && !id_oor && in_use_q[id_idx]
			&& (count_q != CW'(POOL_DEPTH));
		head_inc = (head_q == IW'(POOL_DEPTH - 1)) ? '0 : head_q + 1'b1;
		tail_inc = (tail_q == IW'(POOL_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	end

	// Queue storage: registered read at the head, write at the tail on a successful free.
	always_ff @(posedge clk) begin
		rd_q <= queue_mem[head_q];
		if (cmd.exec && free_ok) begin
			queue_mem[tail_q] <= id_idx;
		end
	end

	// Pool state: reinitialised on reset and on a pool size write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= IW'(RST_TAIL);
			tail0_q  <= IW'(RST_TAIL);
			count_q  <= CW'(RST_EFF);
			fill_q   <= '0;
			in_use_q <= '0;
		end else if (cfg_we) begin
			head_q   <= '0;
			tail_q   <= cfg_tail;
			tail0_q  <= cfg_tail;
			count_q  <= cfg_eff;
			fill_q   <= '0;
			in_use_q <= '0;
		end else if (cmd.exec) begin
			if (alloc_ok) begin
				head_q          <= head_inc;
				count_q         <= count_q - 1'b1;
				in_use_q[grant] <= 1'b1;
			end else if (free_ok) begin
				tail_q           <= tail_inc;
				count_q          <= count_q + 1'b1;
				in_use_q[id_idx] <= 1'b0;
				if (fill_q != CW'(POOL_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	// Captured item and result register.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= in_data;
		end
		if (cmd.exec) begin
			rsp_q.granted_id <= alloc_ok ? ID_W'(grant) : '0;
			if (req_q.action == ACT_ALLOC) begin
				rsp_q.status <= alloc_ok ? ST_OK : ST_EMPTY;
			end else begin
				rsp_q.status <= free_ok ? ST_OK : ST_NOT_IN_USE;
			end
		end
	end

	assign out_data = rsp_q;

endmodule
